// ===== rtl/core/fscp_pkg.sv =====
// ----------------------------------------------------------------------------
// Frequency step command parser package
// Shared constants, types and helper functions for the command parser.
// ----------------------------------------------------------------------------
package fscp_pkg;

    // Line buffer capacity; one slot fewer than this holds text bytes.
    localparam int LINE_CAPACITY = 64;
    localparam int CNT_W         = $clog2(LINE_CAPACITY);
    localparam logic [CNT_W-1:0] STORE_LIMIT = CNT_W'(LINE_CAPACITY - 1);

    localparam int STEP_W = 20;
    localparam int FREQ_W = 32;
    localparam logic [STEP_W-1:0] STEP_MAX           = STEP_W'(1000000);
    localparam logic [STEP_W-1:0] DEFAULT_STEP_RESET = STEP_W'(1000);

    // Token counter saturates at four: more than three means too many.
    localparam logic [2:0] TOK_CMD  = 3'd0;
    localparam logic [2:0] TOK_VFO  = 3'd1;
    localparam logic [2:0] TOK_STEP = 3'd2;
    localparam logic [2:0] TOK_MAX  = 3'd4;

    // Command word matcher: count of matched letters, or a failure mark.
    localparam logic [2:0] FREQ_DONE = 3'd4;
    localparam logic [2:0] FREQ_FAIL = 3'd7;
    localparam logic [7:0] FREQ_WORD [4] = '{8'h66, 8'h72, 8'h65, 8'h71};

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_B  = 8'h62;

    typedef enum logic [2:0] {
        ST_OK,
        ST_EMPTY,
        ST_UNKNOWN,
        ST_TOO_MANY,
        ST_BAD_VFO,
        ST_BAD_NUMBER,
        ST_RANGE
    } t_status;

    typedef enum logic [1:0] {
        NUM_SKIP,
        NUM_SIGN,
        NUM_DIGITS,
        NUM_BAD
    } t_num_phase;

    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_A,
        SEL_B,
        SEL_BAD
    } t_vfo_sel;

    // Summary of the line seen so far, handed from the tokeniser to execution.
    typedef struct packed {
        logic              nonempty;
        logic [2:0]        tok_cnt;
        logic [2:0]        freq_state;
        t_vfo_sel          vfo_sel;
        t_num_phase        phase;
        logic              neg;
        logic              over;
        logic [STEP_W-1:0] value;
    } t_line_info;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return (c == CH_LF) || (c == CH_CR);
    endfunction

endpackage

// ===== rtl/core/fscp_in_reg.sv =====
// ----------------------------------------------------------------------------
// Input register
// Holds one received byte until the parser stage consumes it.
// ----------------------------------------------------------------------------
module fscp_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    import fscp_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_in_ready = !r_valid || i_advance;
    assign o_valid    = r_valid;
    assign o_byte     = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_rx_byte;
        end
    end

endmodule

// ===== rtl/core/fscp_tokeniser.sv =====
// ----------------------------------------------------------------------------
// Tokeniser
// Tracks the line one byte at a time: fill count, tokens, command word,
// oscillator letter and the decimal step.
// ----------------------------------------------------------------------------
module fscp_tokeniser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    output fscp_pkg::t_line_info  o_info
);
    import fscp_pkg::*;

    logic [CNT_W-1:0]  r_count,  n_count;
    logic              r_cut,    n_cut;
    logic              r_inside, n_inside;
    logic [2:0]        r_tok_cnt, n_tok_cnt;
    logic [2:0]        r_freq,   n_freq;
    t_vfo_sel          r_sel,    n_sel;
    t_num_phase        r_phase,  n_phase;
    logic              r_neg,    n_neg;
    logic              r_over,   n_over;
    logic [STEP_W-1:0] r_value,  n_value;

    logic [2:0]        idx;
    logic [7:0]        c;
    logic              digit;
    logic [3:0]        d;
    logic [STEP_W+3:0] prod;

    always_comb begin
        n_count   = r_count;
        n_cut     = r_cut;
        n_inside  = r_inside;
        n_tok_cnt = r_tok_cnt;
        n_freq    = r_freq;
        n_sel     = r_sel;
        n_phase   = r_phase;
        n_neg     = r_neg;
        n_over    = r_over;
        n_value   = r_value;
        idx       = TOK_CMD;
        c         = fold(i_byte);
        digit     = (c >= CH_ZERO) && (c <= CH_NINE);
        d         = 4'(c - CH_ZERO);
        prod      = ({4'd0, r_value} << 3) + ({4'd0, r_value} << 1)
                  + {{STEP_W{1'b0}}, d};

        if (i_step) begin
            if (is_eol(i_byte)) begin
                n_count   = '0;
                n_cut     = 1'b0;
                n_inside  = 1'b0;
                n_tok_cnt = '0;
                n_freq    = '0;
                n_sel     = SEL_NONE;
                n_phase   = NUM_SKIP;
                n_neg     = 1'b0;
                n_over    = 1'b0;
                n_value   = '0;
            end else if (r_count < STORE_LIMIT) begin
                n_count = r_count + 1'b1;
                if (!r_cut) begin
                    if (i_byte == CH_NUL) begin
                        n_cut = 1'b1;
                    end else if (i_byte == CH_SPACE) begin
                        n_inside = 1'b0;
                    end else begin
                        n_inside = 1'b1;
                        if (!r_inside) begin
                            idx = r_tok_cnt;
                            if (r_tok_cnt < TOK_MAX) begin
                                n_tok_cnt = r_tok_cnt + 3'd1;
                            end
                        end else begin
                            idx = r_tok_cnt - 3'd1;
                        end

                        case (idx)
                            TOK_CMD: begin
                                if (r_freq < FREQ_DONE && c == FREQ_WORD[r_freq[1:0]]) begin
                                    n_freq = r_freq + 3'd1;
                                end else begin
                                    n_freq = FREQ_FAIL;
                                end
                            end
                            TOK_VFO: begin
                                // Only a single letter a or b is a valid selector.
                                if (r_sel == SEL_NONE && c == CH_LO_A) begin
                                    n_sel = SEL_A;
                                end else if (r_sel == SEL_NONE && c == CH_LO_B) begin
                                    n_sel = SEL_B;
                                end else begin
                                    n_sel = SEL_BAD;
                                end
                            end
                            TOK_STEP: begin
                                case (r_phase) inside
                                    NUM_SKIP: begin
                                        if (i_byte == CH_TAB || i_byte == CH_VT
                                            || i_byte == CH_FF) begin
                                            n_phase = NUM_SKIP;
                                        end else if (i_byte == CH_PLUS
                                                     || i_byte == CH_MINUS) begin
                                            n_phase = NUM_SIGN;
                                            n_neg   = (i_byte == CH_MINUS);
                                        end else if (digit) begin
                                            n_phase = NUM_DIGITS;
                                        end else begin
                                            n_phase = NUM_BAD;
                                        end
                                    end
                                    NUM_SIGN, NUM_DIGITS: begin
                                        n_phase = digit ? NUM_DIGITS : NUM_BAD;
                                    end
                                    default: begin
                                        n_phase = NUM_BAD;
                                    end
                                endcase
                                // Once the value passes the limit it is frozen.
                                if (digit && r_phase != NUM_BAD && !r_over) begin
                                    if (prod > {4'd0, STEP_MAX}) begin
                                        n_over = 1'b1;
                                    end else begin
                                        n_value = prod[STEP_W-1:0];
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cut     <= 1'b0;
            r_inside  <= 1'b0;
            r_tok_cnt <= '0;
            r_freq    <= '0;
            r_sel     <= SEL_NONE;
            r_phase   <= NUM_SKIP;
            r_neg     <= 1'b0;
            r_over    <= 1'b0;
            r_value   <= '0;
        end else begin
            r_count   <= n_count;
            r_cut     <= n_cut;
            r_inside  <= n_inside;
            r_tok_cnt <= n_tok_cnt;
            r_freq    <= n_freq;
            r_sel     <= n_sel;
            r_phase   <= n_phase;
            r_neg     <= n_neg;
            r_over    <= n_over;
            r_value   <= n_value;
        end
    end

    always_comb begin
        o_info.nonempty   = (r_count != '0);
        o_info.tok_cnt    = r_tok_cnt;
        o_info.freq_state = r_freq;
        o_info.vfo_sel    = r_sel;
        o_info.phase      = r_phase;
        o_info.neg        = r_neg;
        o_info.over       = r_over;
        o_info.value      = r_value;
    end

endmodule

// ===== rtl/core/fscp_exec.sv =====
// ----------------------------------------------------------------------------
// Command execution
// Judges a finished line, updates oscillator and frequency, and holds the
// result register towards the output channel.
// ----------------------------------------------------------------------------
module fscp_exec (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  fscp_pkg::t_line_info        i_info,
    input  logic [fscp_pkg::STEP_W-1:0] i_default_step,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [2:0]                  o_status,
    output logic                        o_vfo_now,
    output logic [fscp_pkg::FREQ_W-1:0] o_frequency_now
);
    import fscp_pkg::*;

    logic              r_vfo;
    logic [FREQ_W-1:0] r_freq;
    logic              r_out_valid;
    t_status           r_status;
    logic              r_out_vfo;
    logic [FREQ_W-1:0] r_out_freq;

    t_status           status;
    logic              new_vfo;
    logic [STEP_W-1:0] step;
    logic [FREQ_W-1:0] new_freq;

    always_comb begin
        status  = ST_OK;
        new_vfo = r_vfo;
        step    = i_default_step;
        if (i_info.tok_cnt == 3'd0) begin
            status = ST_EMPTY;
        end else if (i_info.freq_state != FREQ_DONE) begin
            status = ST_UNKNOWN;
        end else if (i_info.tok_cnt == TOK_MAX) begin
            status = ST_TOO_MANY;
        end else if (i_info.tok_cnt > TOK_VFO
                     && i_info.vfo_sel != SEL_A && i_info.vfo_sel != SEL_B) begin
            status = ST_BAD_VFO;
        end else if (i_info.tok_cnt > TOK_STEP && i_info.phase != NUM_DIGITS) begin
            status = ST_BAD_NUMBER;
        end else if (i_info.tok_cnt > TOK_STEP
                     && (i_info.over || i_info.neg || i_info.value == '0)) begin
            status = ST_RANGE;
        end else begin
            if (i_info.tok_cnt > TOK_STEP) begin
                step = i_info.value;
            end
            if (i_info.tok_cnt > TOK_VFO) begin
                new_vfo = (i_info.vfo_sel == SEL_B);
            end
        end
        new_freq = (status == ST_OK) ? r_freq + FREQ_W'(step) : r_freq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vfo       <= 1'b0;
            r_freq      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_fire) begin
                r_vfo       <= new_vfo;
                r_freq      <= new_freq;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_status   <= status;
            r_out_vfo  <= new_vfo;
            r_out_freq <= new_freq;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_vfo_now       = r_out_vfo;
    assign o_frequency_now = r_out_freq;

endmodule

// ===== rtl/core/frequency_step_command_parser_core.sv =====
// ----------------------------------------------------------------------------
// Frequency step command parser core
// Builds command lines from received bytes and executes "freq [a|b] [step]".
// ----------------------------------------------------------------------------
// Throughput: one byte beat per cycle, sustained, while results are taken.
// Result path: a line-ending beat goes from the input register through the
//   execution logic into the result register, which drives o_out_valid.
// Stalls: a line-ending beat waits in the input register only while an untaken
//   result holds the result register; every other beat passes straight on.
// Reset (synchronous, active low): empty line, oscillator A, frequency 0, step 1000.
// ----------------------------------------------------------------------------
module frequency_step_command_parser_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Received byte channel.
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_rx_byte,
    // Result channel.
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [2:0]                  o_status,
    output logic                        o_vfo_now,
    output logic [fscp_pkg::FREQ_W-1:0] o_frequency_now,
    // Default step register.
    input  logic                        i_cfg_we,
    input  logic [fscp_pkg::STEP_W-1:0] i_cfg_wdata
);
    import fscp_pkg::*;

    logic [STEP_W-1:0] r_default_step;

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       advance;
    logic       fire;
    logic       ends_line;
    t_line_info info;

    // The user must write the default step only while the parser is idle; the block
    // does not enforce it. So held, it can feed the execution logic directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_step <= DEFAULT_STEP_RESET;
        end else if (i_cfg_we) begin
            r_default_step <= i_cfg_wdata;
        end
    end

    // A byte that ends a non-empty line produces a result, so it may only
    // leave the input register when the result register is free or is being
    // emptied in the same cycle. Every other byte moves on unconditionally,
    // which keeps the byte channel running while a result waits.
    assign ends_line = byte_valid && is_eol(byte_data) && info.nonempty;
    assign advance   = byte_valid && (!ends_line || !o_out_valid || i_out_ready);
    assign fire      = advance && ends_line;

    fscp_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .i_advance  (advance),
        .o_valid    (byte_valid),
        .o_byte     (byte_data)
    );

    // The tokeniser keeps a running summary of the line, so that nothing of
    // the text itself needs to be stored.
    fscp_tokeniser u_tokeniser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (byte_data),
        .o_info  (info)
    );

    // Execution reads the summary as it stood before the line-ending byte,
    // which is exactly the complete line.
    fscp_exec u_exec (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_info          (info),
        .i_default_step  (r_default_step),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_vfo_now       (o_vfo_now),
        .o_frequency_now (o_frequency_now)
    );

endmodule

// ===== rtl/core/fscp_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Watches the parser's ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module fscp_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_ready,
    input  logic [7:0]                  i_rx_byte,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic [2:0]                  o_status,
    input  logic                        o_vfo_now,
    input  logic [fscp_pkg::FREQ_W-1:0] o_frequency_now
);
    import fscp_pkg::*;

    // The result channel is empty at the first edge after reset is released.
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid straight after reset");

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_vfo_now) && $stable(o_frequency_now))
        else $error("stalled result changed");

    // A fresh result follows a line-ending beat accepted earlier.
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready
            && (i_rx_byte == CH_LF || i_rx_byte == CH_CR), 2))
        else $error("result without a line-ending beat");

    // The byte channel only stalls behind a waiting, untaken result.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("byte channel stalled without output back-pressure");

endmodule

bind frequency_step_command_parser_core fscp_checker u_fscp_checker (.*);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Frequency step command parser testbench
// Sends byte streams that form command lines, with random gaps, and checks
// each status report against a predictor that tracks the line buffer, the
// oscillator selection and the accumulated frequency.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fscp_pkg::*;

    // Quiet cycles required before a step write or the end of an idle pause.
    localparam int unsigned SETTLE_CYCLES = 6;
    // Long hold-off on the result side, used to back the parser up.
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam logic [31:0] FREQ_TEXT     = "freq";

    // One entry of the sender's plan: a byte beat, a default step write, or a
    // pause until every outstanding report has been received.
    typedef enum logic [1:0] {
        ACT_BYTE,
        ACT_STEP_WRITE,
        ACT_WAIT_IDLE
    } t_act_kind;

    typedef struct {
        t_act_kind         kind;
        logic [STEP_W-1:0] value;
        int unsigned       gap;
    } t_plan_entry;

    typedef struct {
        t_status           status;
        logic              vfo;
        logic [FREQ_W-1:0] freq;
    } t_report;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    logic [7:0]        i_rx_byte   = 8'h00;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [2:0]        o_status;
    logic              o_vfo_now;
    logic [FREQ_W-1:0] o_frequency_now;
    logic              i_cfg_we    = 1'b0;
    logic [STEP_W-1:0] i_cfg_wdata = '0;

    frequency_step_command_parser_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_vfo_now       (o_vfo_now),
        .o_frequency_now (o_frequency_now),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: our own copy of the line buffer, the default step and
    // the tuning state, advanced once per accepted byte beat.
    // ------------------------------------------------------------------------
    logic [7:0]        line_text [LINE_CAPACITY];
    int unsigned       line_fill;
    logic [STEP_W-1:0] step_setting;
    logic              vfo_model;
    logic [FREQ_W-1:0] freq_model;

    t_report           expected_reports [$];
    t_plan_entry       tx_plan [$];

    int unsigned       error_count    = 0;
    int unsigned       bytes_queued   = 0;
    int unsigned       bytes_accepted = 0;
    int unsigned       reports_seen   = 0;
    int unsigned       step_writes    = 0;
    int unsigned       idle_pauses    = 0;
    int unsigned       quiet_cycles   = 0;
    int unsigned       stall_left     = 0;
    int unsigned       cycle_count    = 0;
    int unsigned       status_tally [7];
    bit                calm_line      = 1'b0;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            return c | 8'h20;
        end
        return c;
    endfunction

    // Interprets the stored line and applies it to the tuning state when it is
    // a valid command. Errors leave the oscillator and frequency untouched.
    function automatic t_status execute_line();
        int unsigned       text_end;
        int unsigned       pos;
        int unsigned       first;
        int unsigned       last;
        int unsigned       tok_count;
        int unsigned       tok_at [3];
        int unsigned       tok_len [3];
        int unsigned       value;
        int unsigned       digits;
        bit                neg;
        bit                over;
        logic              next_vfo;
        logic [7:0]        c;
        logic [FREQ_W-1:0] step;

        // The text ends at the first NUL, even though later bytes are stored.
        text_end = 0;
        while (text_end < line_fill && line_text[text_end] != CH_NUL) begin
            text_end++;
        end

        // Tokens are separated by spaces only; the count saturates at four.
        tok_count = 0;
        pos = 0;
        while (pos < text_end) begin
            if (line_text[pos] == CH_SPACE) begin
                pos++;
            end else begin
                first = pos;
                while (pos < text_end && line_text[pos] != CH_SPACE) begin
                    pos++;
                end
                if (tok_count < 3) begin
                    tok_at[tok_count]  = first;
                    tok_len[tok_count] = pos - first;
                end
                if (tok_count < 4) begin
                    tok_count++;
                end
            end
        end

        if (tok_count == 0) begin
            return ST_EMPTY;
        end
        if (tok_len[0] != 4) begin
            return ST_UNKNOWN;
        end
        for (int k = 0; k < 4; k++) begin
            if (to_lower(line_text[tok_at[0] + k]) != FREQ_TEXT[31 - 8 * k -: 8]) begin
                return ST_UNKNOWN;
            end
        end
        if (tok_count > 3) begin
            return ST_TOO_MANY;
        end

        next_vfo = vfo_model;
        if (tok_count >= 2) begin
            if (tok_len[1] != 1) begin
                return ST_BAD_VFO;
            end
            c = to_lower(line_text[tok_at[1]]);
            if (c == CH_LO_A) begin
                next_vfo = 1'b0;
            end else if (c == CH_LO_B) begin
                next_vfo = 1'b1;
            end else begin
                return ST_BAD_VFO;
            end
        end

        step = FREQ_W'(step_setting);
        if (tok_count == 3) begin
            // Step token: any run of tab, VT or FF, an optional sign, then digits.
            pos  = tok_at[2];
            last = tok_at[2] + tok_len[2];
            while (pos < last && (line_text[pos] == CH_TAB || line_text[pos] == CH_VT ||
                                  line_text[pos] == CH_FF)) begin
                pos++;
            end
            neg = 1'b0;
            if (pos < last && (line_text[pos] == CH_PLUS || line_text[pos] == CH_MINUS)) begin
                neg = (line_text[pos] == CH_MINUS);
                pos++;
            end
            value  = 0;
            digits = 0;
            over   = 1'b0;
            while (pos < last && line_text[pos] >= CH_ZERO && line_text[pos] <= CH_NINE) begin
                // Once past the maximum the value is frozen and flagged.
                if (!over) begin
                    value = value * 10 + (line_text[pos] - CH_ZERO);
                    if (value > STEP_MAX) begin
                        over = 1'b1;
                    end
                end
                digits++;
                pos++;
            end
            if (digits == 0 || pos != last) begin
                return ST_BAD_NUMBER;
            end
            if (over || neg || value == 0) begin
                return ST_RANGE;
            end
            step = value;
        end

        freq_model = freq_model + step;
        vfo_model  = next_vfo;
        return ST_OK;
    endfunction

    // Advances the predictor by one accepted byte beat. A CR or LF with an
    // empty buffer is ignored; otherwise it produces exactly one report.
    function automatic void apply_rx_byte(input logic [7:0] b);
        t_report r;
        if (b == CH_LF || b == CH_CR) begin
            if (line_fill != 0) begin
                r.status = execute_line();
                r.vfo    = vfo_model;
                r.freq   = freq_model;
                expected_reports.push_back(r);
                status_tally[int'(r.status)]++;
                line_fill = 0;
            end
        end else if (line_fill < LINE_CAPACITY - 1) begin
            line_text[line_fill] = b;
            line_fill++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Plan building helpers used by the stimulus block.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] random_text_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == CH_LF || b == CH_CR);
        return b;
    endfunction

    task automatic add_byte(input logic [7:0] b);
        t_plan_entry e;
        e.kind  = ACT_BYTE;
        e.value = STEP_W'(b);
        e.gap   = calm_line ? 0 : $urandom_range(0, 6);
        tx_plan.push_back(e);
        bytes_queued++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_byte(s[i]);
        end
    endtask

    task automatic add_eol();
        add_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    endtask

    task automatic add_line(input string s);
        add_text(s);
        add_eol();
    endtask

    task automatic add_mixed_case(input string w);
        logic [7:0] c;
        for (int i = 0; i < w.len(); i++) begin
            c = w[i];
            if (c >= CH_LO_A && c <= "z" && $urandom_range(0, 1) == 1) begin
                c = c - 8'd32;
            end
            add_byte(c);
        end
    endtask

    task automatic add_spaces(input int unsigned n);
        repeat (n) add_byte(CH_SPACE);
    endtask

    task automatic add_step_write(input logic [STEP_W-1:0] v);
        t_plan_entry e;
        e.kind  = ACT_STEP_WRITE;
        e.value = v;
        e.gap   = 0;
        tx_plan.push_back(e);
    endtask

    task automatic add_idle_wait();
        t_plan_entry e;
        e.kind  = ACT_WAIT_IDLE;
        e.value = '0;
        e.gap   = 0;
        tx_plan.push_back(e);
    endtask

    // A step token, leaning towards the range limits and the syntax corners.
    task automatic add_step_token();
        int unsigned ws;
        case ($urandom_range(0, 11))
            0: add_text("1");
            1: add_text("1000000");
            2: add_text("1000001");
            3: add_text("0");
            4: add_text($sformatf("-%0d", $urandom_range(0, 1000000)));
            5: add_text($sformatf("+%0d", $urandom_range(1, 1000000)));
            6: begin
                repeat ($urandom_range(1, 3)) begin
                    ws = $urandom_range(0, 2);
                    add_byte(ws == 0 ? CH_TAB : (ws == 1 ? CH_VT : CH_FF));
                end
                add_text($sformatf("%0d", $urandom_range(1, 999)));
            end
            7: add_text($sformatf("%0d%05d", $urandom_range(1, 99999), $urandom_range(0, 99999)));
            8: add_text($sformatf("%0dk", $urandom_range(0, 500)));
            9: add_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            10: add_text($sformatf("00%0d", $urandom_range(0, 99999)));
            default: add_text($sformatf("%0d", $urandom_range(1, 1000000)));
        endcase
    endtask

    // Mostly well-formed commands with random content, the rest noise, long
    // lines, embedded NULs, unknown words and blank lines.
    task automatic add_random_line();
        int unsigned pick;
        calm_line = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        add_spaces($urandom_range(0, 1));
        if (pick < 70) begin
            add_mixed_case("freq");
            if ($urandom_range(0, 3) != 0) begin
                add_spaces($urandom_range(1, 2));
                case ($urandom_range(0, 9))
                    0: add_mixed_case("c");
                    1: add_mixed_case("ab");
                    2: add_byte(random_text_byte());
                    default: add_mixed_case($urandom_range(0, 1) ? "a" : "b");
                endcase
                if ($urandom_range(0, 3) != 0) begin
                    add_spaces($urandom_range(1, 2));
                    add_step_token();
                    if ($urandom_range(0, 9) == 0) begin
                        add_byte(CH_SPACE);
                        add_mixed_case("x");
                    end
                end
            end
            add_spaces($urandom_range(0, 1));
        end else if (pick < 78) begin
            repeat ($urandom_range(1, 20)) add_byte(random_text_byte());
        end else if (pick < 84) begin
            // May run past the buffer capacity, in which case the tail is dropped.
            add_mixed_case("freq a ");
            add_step_token();
            repeat ($urandom_range(40, 80)) begin
                add_byte($urandom_range(0, 3) == 0 ? random_text_byte() : CH_SPACE);
            end
        end else if (pick < 90) begin
            if ($urandom_range(0, 1) == 0) begin
                add_byte(CH_NUL);
                add_text("freq a 5");
            end else begin
                add_mixed_case("freq b");
                add_byte(CH_NUL);
                repeat ($urandom_range(1, 5)) add_byte(random_text_byte());
            end
        end else if (pick < 95) begin
            case ($urandom_range(0, 4))
                0: add_mixed_case("fre");
                1: add_mixed_case("freqq");
                2: add_mixed_case("frex 5");
                3: add_mixed_case("step a 10");
                default: add_mixed_case("f r e q");
            endcase
        end else begin
            add_spaces($urandom_range(0, 4));
        end
        add_eol();
    endtask

    // ------------------------------------------------------------------------
    // Byte driver: offers the planned beats, writes the default step only when
    // nothing is in flight, and feeds every accepted beat to the predictor.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : byte_driver
        bit taken;
        bit next_valid;
        bit next_we;
        if (!i_rst_n) begin
            i_in_valid   <= 1'b0;
            i_cfg_we     <= 1'b0;
            quiet_cycles = 0;
        end else begin
            taken      = i_in_valid && o_in_ready;
            next_valid = i_in_valid && !taken;
            next_we    = 1'b0;
            if (taken) begin
                bytes_accepted++;
                apply_rx_byte(i_rx_byte);
            end

            // The parser is idle once no beat is offered and every report
            // has come back; count how long that has lasted.
            if (i_in_valid || i_cfg_we || expected_reports.size() != 0) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end

            if (!next_valid && tx_plan.size() != 0) begin
                case (tx_plan[0].kind)
                    ACT_BYTE: begin
                        if (tx_plan[0].gap != 0) begin
                            tx_plan[0].gap = tx_plan[0].gap - 1;
                        end else begin
                            i_rx_byte  <= tx_plan[0].value[7:0];
                            next_valid = 1'b1;
                            void'(tx_plan.pop_front());
                        end
                    end
                    ACT_STEP_WRITE: begin
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            i_cfg_wdata  <= tx_plan[0].value;
                            next_we      = 1'b1;
                            step_setting = tx_plan[0].value;
                            step_writes++;
                            void'(tx_plan.pop_front());
                        end
                    end
                    ACT_WAIT_IDLE: begin
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            idle_pauses++;
                            void'(tx_plan.pop_front());
                        end
                    end
                    default: begin
                        void'(tx_plan.pop_front());
                    end
                endcase
            end
            i_in_valid <= next_valid;
            i_cfg_we   <= next_we;
        end
    end

    // ------------------------------------------------------------------------
    // Report monitor: stalls at random, with calm stretches and two long
    // hold-offs, and checks each accepted report against the oldest
    // expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : report_monitor
        t_report want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  = 0;
        end else begin
            if (i_out_ready && o_out_valid) begin
                if (expected_reports.size() == 0) begin
                    error_count++;
                    $display("%0t ns: unexpected report, status %0d vfo %0d freq %0d",
                             $time, o_status, o_vfo_now, o_frequency_now);
                end else begin
                    want = expected_reports.pop_front();
                    if (o_status !== want.status) begin
                        error_count++;
                        $display("%0t ns: status mismatch, expected %0d, got %0d",
                                 $time, want.status, o_status);
                    end
                    if (o_vfo_now !== want.vfo) begin
                        error_count++;
                        $display("%0t ns: vfo mismatch, expected %0d, got %0d",
                                 $time, want.vfo, o_vfo_now);
                    end
                    if (o_frequency_now !== want.freq) begin
                        error_count++;
                        $display("%0t ns: frequency mismatch, expected %0d, got %0d",
                                 $time, want.freq, o_frequency_now);
                    end
                end
                reports_seen++;
                // Every third stretch of twenty reports runs without stalls.
                stall_left = ((reports_seen / 20) % 3 == 2) ? 0 : $urandom_range(0, 6);
                if (reports_seen == 30 || reports_seen == 70) begin
                    stall_left = HOLD_CYCLES;
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timed out with %0d plan entries and %0d reports outstanding",
                     $time, tx_plan.size(), expected_reports.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: a directed set of lines first, then random phases, each under
    // its own default step.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned       target;
        logic [STEP_W-1:0] new_step;

        line_fill    = 0;
        step_setting = DEFAULT_STEP_RESET;
        vfo_model    = 1'b0;
        freq_model   = '0;
        foreach (status_tally[i]) status_tally[i] = 0;

        // Line ends on an empty buffer produce nothing.
        add_byte(CH_CR);
        add_byte(CH_LF);
        // The reset default step, then the step limits and sign handling.
        add_line("freq");
        add_line("FREQ A");
        add_line("freq b 1");
        add_line("freq a 1000000");
        add_line("freq a 1000001");
        add_line("freq b 0");
        add_line("freq b -5");
        add_line("Freq B +7");
        add_text("freq a ");
        add_byte(CH_TAB);
        add_byte(CH_VT);
        add_byte(CH_FF);
        add_line("12");
        add_line("freq b 12x");
        add_line("freq b -");
        add_line("freq a 99999999999");
        // Blank text: spaces only, or a NUL at the very start.
        add_line("   ");
        add_byte(CH_NUL);
        add_line("freq");
        // Unknown words take precedence over a token count that is too high.
        add_line("hello");
        add_line("fre");
        add_line("freq\ta");
        add_line("frequency a b c");
        add_line("freq a 5 6");
        add_line("freq c");
        add_line("freq ab 5");
        add_text("freq ");
        add_byte(8'hE1);
        add_eol();
        // A NUL ends the text; what follows it is ignored.
        add_text("freq b 5");
        add_byte(CH_NUL);
        add_line(" junk");
        // Too long: the trailing digit falls beyond the buffer and is dropped.
        add_text("freq b 12");
        add_spaces(60);
        add_line("9");
        // Hold the sender until everything is back, then try the step extremes.
        add_idle_wait();
        add_step_write('0);
        add_line("freq a");
        add_step_write(STEP_MAX);
        add_line("freq b");

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: new_step = STEP_MAX;
                1: new_step = STEP_W'($urandom_range(1, 999999));
                2: new_step = '0;
                3: new_step = STEP_W'($urandom_range(0, 1000000));
                default: new_step = STEP_W'(1);
            endcase
            add_step_write(new_step);
            target = bytes_queued + 220;
            while (bytes_queued < target) begin
                add_random_line();
            end
            if (phase == 1) begin
                add_idle_wait();
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (tx_plan.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);

        $display("Run covered %0d byte beats, %0d reports, %0d step writes, %0d idle pauses.",
                 bytes_accepted, reports_seen, step_writes, idle_pauses);
        $display("Reports by status: ok %0d, empty %0d, unknown %0d, too many %0d, %s %0d %0d %0d",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3],
                 "bad vfo / bad number / range", status_tally[4], status_tally[5],
                 status_tally[6]);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/fscp_pkg.sv
rtl/core/fscp_in_reg.sv
rtl/core/fscp_tokeniser.sv
rtl/core/fscp_exec.sv
rtl/core/frequency_step_command_parser_core.sv
rtl/core/fscp_checker.sv
tb/tb.sv
